FILE: rtl/ffsa_pkg.sv
// ----------------------------------------------------------------------------
// ffsa_pkg: shared types and constants for the first-fit segment allocator
// Pool and table sizes, status codes, state encoding and the segment word.
// ----------------------------------------------------------------------------
package ffsa_pkg;

    localparam int POOL_BYTES = 65536;
    localparam int SEGMENTS   = 256;
    localparam int IDX_W      = $clog2(SEGMENTS);
    localparam int CNT_W      = $clog2(SEGMENTS + 1);
    localparam int POS_W      = $clog2(POOL_BYTES + 1);
    localparam int AMT_W      = 17;
    localparam int OFS_W      = 16;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_SPACE   = 3'd1,
        ST_NOT_FOUND  = 3'd2,
        ST_TABLE_FULL = 3'd3,
        ST_BAD_SIZE   = 3'd4
    } status_t;

    typedef struct packed {
        logic [POS_W-1:0] start;
        logic [POS_W-1:0] size;
        logic             free;
    } seg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_CHK,
        S_ALLOC,
        S_SHUP_RD,
        S_SHUP_WR,
        S_NEXT_RD,
        S_NEXT_CHK,
        S_PREV_RD,
        S_PREV_CHK,
        S_SHDN_RD,
        S_SHDN_WR,
        S_DONE
    } state_t;

endpackage

FILE: rtl/ffsa_if.sv
// ----------------------------------------------------------------------------
// ffsa_if: valid/ready channel carrying one word of type T
// Source drives valid and payload, sink drives ready.
// ----------------------------------------------------------------------------
interface ffsa_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/first_fit_segment_allocator.sv
// First-fit segment allocator.
// A rejected size goes straight to the done state; a scan reads one entry at a
// time, and a split or merge shifts entries with a read and a write for each.
// One request in flight; the next is taken once the response register frees.
// Reset (async, active low) leaves one free segment spanning the pool; entry 0
// is written in the first cycle after reset, during which no word is taken.
// ----------------------------------------------------------------------------
// first_fit_segment_allocator: top level
// Segment table memory plus request sequencer.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator
    import ffsa_pkg::*;
(
    input logic clk,
    input logic rst_n,
    ffsa_if.sink   req,
    ffsa_if.source rsp
);

    logic             we;
    logic [IDX_W-1:0] waddr, raddr;
    seg_t             wdata, rdata;
    status_t          st;

    ffsa_seg_ram u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    ffsa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_ready  (req.ready),
        .req_mode   (req.data.mode),
        .req_amount (req.data.amount),
        .req_offset (req.data.offset),
        .rsp_valid  (rsp.valid),
        .rsp_ready  (rsp.ready),
        .rsp_status (st),
        .rsp_start  (rsp.data.block_start),
        .we         (we),
        .waddr      (waddr),
        .wdata      (wdata),
        .raddr      (raddr),
        .rdata      (rdata)
    );

    assign rsp.data.status = st;

endmodule

FILE: rtl/ffsa_seg_ram.sv
// ----------------------------------------------------------------------------
// ffsa_seg_ram: segment table storage
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffsa_seg_ram
    import ffsa_pkg::*;
(
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  seg_t             wdata,
    input  logic [IDX_W-1:0] raddr,
    output seg_t             rdata
);

    seg_t mem [SEGMENTS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/ffsa_ctrl.sv
// ----------------------------------------------------------------------------
// ffsa_ctrl: request sequencer
// Scans the table, splits or merges segments and shifts entries one at a time,
// with a read and a write each, through the single-port-read segment memory.
// ----------------------------------------------------------------------------
module ffsa_ctrl
    import ffsa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  logic             req_mode,
    input  logic [AMT_W-1:0] req_amount,
    input  logic [OFS_W-1:0] req_offset,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output status_t          rsp_status,
    output logic [OFS_W-1:0] rsp_start,
    output logic             we,
    output logic [IDX_W-1:0] waddr,
    output seg_t             wdata,
    output logic [IDX_W-1:0] raddr,
    input  seg_t             rdata
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;   // current entry
    logic [CNT_W-1:0] ptr_reg, ptr_next;   // shift pointer
    logic             mode_reg, mode_next;
    logic [POS_W-1:0] amt_reg, amt_next;
    logic [OFS_W-1:0] ofs_reg, ofs_next;
    seg_t             cur_reg, cur_next;   // entry to allocate, free or merge
    seg_t             merge_seg;
    logic             mprev_reg, mprev_next;
    logic             rv_reg, rv_next;
    status_t          st_reg, st_next;
    logic [OFS_W-1:0] bs_reg, bs_next;
    logic [AMT_W:0]   amt_ext;

    // boundary values of the pool start at zero for entry 0
    seg_t             init_seg;
    logic [POS_W-1:0] pool_val;

    assign pool_val = POS_W'(POOL_BYTES);
    assign init_seg = '{start: '0, size: pool_val, free: 1'b1};
    assign amt_ext  = {1'b0, req_amount};

    // entry 0 is written while init_reg, set by reset, is still high
    logic init_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= CNT_W'(1);
            rv_reg    <= 1'b0;
            init_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rv_reg    <= rv_next;
            init_reg  <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        ptr_reg   <= ptr_next;
        mode_reg  <= mode_next;
        amt_reg   <= amt_next;
        ofs_reg   <= ofs_next;
        cur_reg   <= cur_next;
        mprev_reg <= mprev_next;
        st_reg    <= st_next;
        bs_reg    <= bs_next;
    end

    assign rsp_valid  = rv_reg;
    assign rsp_status = st_reg;
    assign rsp_start  = bs_reg;
    assign req_ready  = (state_reg == S_IDLE) && !init_reg && (!rv_reg || rsp_ready);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        ptr_next   = ptr_reg;
        mode_next  = mode_reg;
        amt_next   = amt_reg;
        ofs_next   = ofs_reg;
        cur_next   = cur_reg;
        merge_seg  = rdata;
        mprev_next = mprev_reg;
        st_next    = st_reg;
        bs_next    = bs_reg;
        rv_next    = rv_reg && !rsp_ready;
        we         = 1'b0;
        waddr      = idx_reg[IDX_W-1:0];
        wdata      = cur_reg;
        raddr      = idx_reg[IDX_W-1:0];

        if (init_reg)
        begin
            we    = 1'b1;
            waddr = '0;
            wdata = init_seg;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid && req_ready)
                begin
                    mode_next = req_mode;
                    amt_next  = POS_W'(req_amount);
                    ofs_next  = req_offset;
                    idx_next  = '0;
                    st_next   = ST_OK;
                    bs_next   = '0;
                    raddr     = '0;
                    if (!req_mode && (req_amount == '0
                        || amt_ext > (AMT_W+1)'(POOL_BYTES)))
                    begin
                        st_next    = ST_BAD_SIZE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN_CHK;
                    end
                end
            end

            S_SCAN:
            begin
                raddr      = idx_reg[IDX_W-1:0];
                state_next = S_SCAN_CHK;
            end

            S_SCAN_CHK:
            begin
                if (!mode_reg ? (rdata.free && rdata.size >= amt_reg)
                              : (rdata.start == POS_W'(ofs_reg)))
                begin
                    cur_next = rdata;
                    if (!mode_reg)
                    begin
                        state_next = S_ALLOC;
                    end
                    else
                    begin
                        cur_next.free = 1'b1;
                        state_next    = S_NEXT_RD;
                    end
                end
                else if (idx_reg + CNT_W'(1) >= count_reg)
                begin
                    st_next    = mode_reg ? ST_NOT_FOUND : ST_NO_SPACE;
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    raddr      = idx_next[IDX_W-1:0];
                    state_next = S_SCAN_CHK;
                end
            end

            S_ALLOC:
            begin
                if (cur_reg.size == amt_reg)
                begin
                    we         = 1'b1;
                    wdata      = '{start: cur_reg.start, size: cur_reg.size, free: 1'b0};
                    bs_next    = cur_reg.start[OFS_W-1:0];
                    state_next = S_DONE;
                end
                else if (count_reg >= CNT_W'(SEGMENTS))
                begin
                    st_next    = ST_TABLE_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    ptr_next   = count_reg;
                    state_next = S_SHUP_RD;
                end
            end

            // open a hole at idx+1: move entry ptr-1 to ptr, ptr down to idx+2
            S_SHUP_RD:
            begin
                if (ptr_reg == idx_reg + CNT_W'(1))
                begin
                    we         = 1'b1;
                    waddr      = ptr_reg[IDX_W-1:0];
                    wdata      = '{start: cur_reg.start + amt_reg,
                                   size: cur_reg.size - amt_reg, free: 1'b1};
                    state_next = S_SHUP_WR;
                    ptr_next   = '0;
                end
                else
                begin
                    raddr      = ptr_reg[IDX_W-1:0] - IDX_W'(1);
                    state_next = S_SHUP_WR;
                end
            end

            S_SHUP_WR:
            begin
                if (ptr_reg == '0)
                begin
                    we         = 1'b1;
                    wdata      = '{start: cur_reg.start, size: amt_reg, free: 1'b0};
                    bs_next    = cur_reg.start[OFS_W-1:0];
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    we         = 1'b1;
                    waddr      = ptr_reg[IDX_W-1:0];
                    wdata      = rdata;
                    ptr_next   = ptr_reg - CNT_W'(1);
                    state_next = S_SHUP_RD;
                end
            end

            S_NEXT_RD:
            begin
                if (idx_reg + CNT_W'(1) < count_reg)
                begin
                    raddr      = idx_reg[IDX_W-1:0] + IDX_W'(1);
                    state_next = S_NEXT_CHK;
                end
                else
                begin
                    state_next = S_PREV_RD;
                end
            end

            S_NEXT_CHK:
            begin
                if (rdata.free)
                begin
                    cur_next.size = cur_reg.size + rdata.size;
                    mprev_next    = 1'b0;
                    ptr_next      = idx_reg + CNT_W'(1);
                    we            = 1'b1;
                    wdata         = cur_next;
                    state_next    = S_SHDN_RD;
                end
                else
                begin
                    state_next = S_PREV_RD;
                end
            end

            S_PREV_RD:
            begin
                if (idx_reg != '0)
                begin
                    raddr      = idx_reg[IDX_W-1:0] - IDX_W'(1);
                    state_next = S_PREV_CHK;
                end
                else
                begin
                    we         = 1'b1;
                    state_next = S_DONE;
                end
            end

            S_PREV_CHK:
            begin
                if (rdata.free)
                begin
                    merge_seg.size = rdata.size + cur_reg.size;
                    we             = 1'b1;
                    waddr          = idx_reg[IDX_W-1:0] - IDX_W'(1);
                    wdata          = merge_seg;
                    mprev_next     = 1'b1;
                    ptr_next       = idx_reg;
                    state_next     = S_SHDN_RD;
                end
                else
                begin
                    we         = 1'b1;
                    state_next = S_DONE;
                end
            end

            // close the gap at ptr: move entry ptr+1 to ptr
            S_SHDN_RD:
            begin
                if (ptr_reg + CNT_W'(1) >= count_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = mprev_reg ? S_DONE : S_PREV_RD;
                end
                else
                begin
                    raddr      = ptr_reg[IDX_W-1:0] + IDX_W'(1);
                    state_next = S_SHDN_WR;
                end
            end

            S_SHDN_WR:
            begin
                we         = 1'b1;
                waddr      = ptr_reg[IDX_W-1:0];
                wdata      = rdata;
                ptr_next   = ptr_reg + CNT_W'(1);
                state_next = S_SHDN_RD;
            end

            S_DONE:
            begin
                if (!rv_reg || rsp_ready)
                begin
                    rv_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/ffsa_checker.sv
// ----------------------------------------------------------------------------
// ffsa_checker: port-level checks for the allocator
// Watches request/response handshakes and response words.
// ----------------------------------------------------------------------------
module ffsa_checker
    import ffsa_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input logic [2:0]       rsp_status,
    input logic [OFS_W-1:0] rsp_start
);

    // no new request while a response is stalled
    a_no_accept_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |-> !req_ready)
        else $error("request taken while response stalled");

    // start is zero unless the status is ok
    a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_status != 3'(ST_OK)) |-> (rsp_start == '0))
        else $error("nonzero start on failed request");

    // a response is never shown in the cycle right after a request is taken
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && !(rsp_valid && !rsp_ready)) |=> !rsp_valid)
        else $error("response too early");

    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)))
        else $error("stalled response changed");

endmodule

bind first_fit_segment_allocator ffsa_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.data.status),
    .rsp_start  (rsp.data.block_start)
);

FILE: tb/first_fit_segment_allocator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_tb: self-checking bench for the segment allocator
// Directed table then random allocate/free traffic under varying idle and
// stall patterns; each response is checked against a typed value or a table model.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator_tb;
    import ffsa_pkg::*;

    typedef struct packed {
        logic             mode;
        logic [AMT_W-1:0] amount;
        logic [OFS_W-1:0] offset;
    } req_word_t;

    typedef struct packed {
        status_t          status;
        logic [OFS_W-1:0] block_start;
    } rsp_word_t;

    typedef struct {
        logic             mode;
        logic [AMT_W-1:0] amount;
        logic [OFS_W-1:0] offset;
        bit               typed;
        status_t          status;
        logic [OFS_W-1:0] block_start;
    } vector_t;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;
    localparam int   STALL_LIMIT = 20000;
    localparam int   DRAIN_CYCLES = 50;

    logic clk;
    logic rst_n;

    ffsa_if #(.T(req_word_t)) req_ch ();
    ffsa_if #(.T(rsp_word_t)) rsp_ch ();

    first_fit_segment_allocator uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // model of the segment table
    int unsigned tbl_start [SEGMENTS];
    int unsigned tbl_size  [SEGMENTS];
    bit          tbl_free  [SEGMENTS];
    int unsigned tbl_count;

    rsp_word_t pending_rsp [$];
    int        errors;
    int        idle_cycles;
    int        send_idle_pct;
    int        recv_stall_pct;
    bit        timed_out;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic rsp_word_t predict_request(logic mode, int unsigned amount,
                                                  int unsigned offset);
        rsp_word_t   r;
        int unsigned i;
        int unsigned j;
        r.status = ST_OK;
        r.block_start = '0;
        if (mode == MODE_ALLOC) begin
            if (amount == 0 || amount > POOL_BYTES) begin
                r.status = ST_BAD_SIZE;
            end
            else begin
                for (i = 0; i < tbl_count; i++)
                    if (tbl_free[i] && tbl_size[i] >= amount)
                        break;
                if (i >= tbl_count) begin
                    r.status = ST_NO_SPACE;
                end
                else if (tbl_size[i] > amount && tbl_count >= SEGMENTS) begin
                    r.status = ST_TABLE_FULL;
                end
                else begin
                    if (tbl_size[i] > amount) begin
                        for (j = tbl_count; j > i + 1; j--) begin
                            tbl_start[j] = tbl_start[j-1];
                            tbl_size[j]  = tbl_size[j-1];
                            tbl_free[j]  = tbl_free[j-1];
                        end
                        tbl_count++;
                        tbl_start[i+1] = tbl_start[i] + amount;
                        tbl_size[i+1]  = tbl_size[i] - amount;
                        tbl_free[i+1]  = 1'b1;
                        tbl_size[i]    = amount;
                    end
                    tbl_free[i] = 1'b0;
                    r.block_start = tbl_start[i][OFS_W-1:0];
                end
            end
        end
        else begin
            for (i = 0; i < tbl_count; i++)
                if (tbl_start[i] == offset)
                    break;
            if (i >= tbl_count) begin
                r.status = ST_NOT_FOUND;
            end
            else begin
                tbl_free[i] = 1'b1;
                if (i + 1 < tbl_count && tbl_free[i+1]) begin
                    tbl_size[i] += tbl_size[i+1];
                    for (j = i + 1; j + 1 < tbl_count; j++) begin
                        tbl_start[j] = tbl_start[j+1];
                        tbl_size[j]  = tbl_size[j+1];
                        tbl_free[j]  = tbl_free[j+1];
                    end
                    tbl_count--;
                end
                if (i > 0 && tbl_free[i-1]) begin
                    tbl_size[i-1] += tbl_size[i];
                    for (j = i; j + 1 < tbl_count; j++) begin
                        tbl_start[j] = tbl_start[j+1];
                        tbl_size[j]  = tbl_size[j+1];
                        tbl_free[j]  = tbl_free[j+1];
                    end
                    tbl_count--;
                end
            end
        end
        return r;
    endfunction

    // start of a random used block, or a random offset if none is in use
    function automatic int unsigned pick_used_start();
        int unsigned used [$];
        for (int k = 0; k < tbl_count; k++)
            if (!tbl_free[k])
                used.push_back(tbl_start[k]);
        if (used.size() == 0)
            return $urandom_range(0, 65535);
        return used[$urandom_range(0, used.size() - 1)];
    endfunction

    // holds the word until accepted; inputs move on the falling edge only
    task automatic send_word(vector_t v);
        rsp_word_t exp;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid = 1'b1;
        req_ch.data  = '{mode: v.mode, amount: v.amount, offset: v.offset};
        do
            @(posedge clk);
        while (!(req_ch.valid && req_ch.ready));
        exp = predict_request(v.mode, 32'(v.amount), 32'(v.offset));
        if (v.typed) begin
            exp.status = v.status;
            exp.block_start = v.block_start;
        end
        pending_rsp.push_back(exp);
        @(negedge clk);
    endtask

    task automatic send_random(int fill_burst, int count);
        vector_t v;
        int      pick;
        v.typed = 1'b0;
        v.status = ST_OK;
        v.block_start = '0;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            v.offset = OFS_W'($urandom);
            v.amount = AMT_W'($urandom);
            if (n < fill_burst) begin
                // small allocations drive the table toward full
                v.mode = MODE_ALLOC;
                v.amount = AMT_W'($urandom_range(1, 8));
            end
            else if (pick < 45) begin
                v.mode = MODE_ALLOC;
                v.amount = AMT_W'($urandom_range(1, 512));
            end
            else if (pick < 55) begin
                v.mode = MODE_ALLOC;
                v.amount = AMT_W'($urandom_range(1, POOL_BYTES));
            end
            else if (pick < 60) begin
                v.mode = MODE_ALLOC;
            end
            else if (pick < 93) begin
                v.mode = MODE_FREE;
                v.offset = OFS_W'(pick_used_start());
            end
            else begin
                v.mode = MODE_FREE;
            end
            send_word(v);
        end
    endtask

    always @(negedge clk)
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge clk) begin
        rsp_word_t exp;
        if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected response status=%0d start=%0d", $time,
                         rsp_ch.data.status, rsp_ch.data.block_start);
                errors++;
            end
            else begin
                exp = pending_rsp.pop_front();
                if (rsp_ch.data.status !== exp.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp.status, rsp_ch.data.status);
                    errors++;
                end
                if (rsp_ch.data.block_start !== exp.block_start) begin
                    $display("%0t: block_start expected %0d actual %0d", $time,
                             exp.block_start, rsp_ch.data.block_start);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT && !timed_out) begin
            timed_out <= 1'b1;
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    vector_t directed [22] = '{
        '{MODE_ALLOC, 17'd0,      16'd0,     1'b1, ST_BAD_SIZE,  16'd0},
        '{MODE_ALLOC, 17'd65537,  16'd0,     1'b1, ST_BAD_SIZE,  16'd0},
        '{MODE_ALLOC, 17'h1FFFF,  16'hFFFF,  1'b1, ST_BAD_SIZE,  16'd0},
        '{MODE_FREE,  17'd0,      16'd5,     1'b1, ST_NOT_FOUND, 16'd0},
        '{MODE_FREE,  17'd0,      16'hFFFF,  1'b1, ST_NOT_FOUND, 16'd0},
        '{MODE_FREE,  17'd0,      16'd0,     1'b1, ST_OK,        16'd0},
        '{MODE_ALLOC, 17'd65536,  16'd0,     1'b1, ST_OK,        16'd0},
        '{MODE_ALLOC, 17'd1,      16'd0,     1'b1, ST_NO_SPACE,  16'd0},
        '{MODE_FREE,  17'd0,      16'd0,     1'b1, ST_OK,        16'd0},
        '{MODE_ALLOC, 17'd1,      16'd0,     1'b1, ST_OK,        16'd0},
        '{MODE_ALLOC, 17'd65534,  16'd0,     1'b1, ST_OK,        16'd1},
        '{MODE_ALLOC, 17'd1,      16'd0,     1'b1, ST_OK,        16'd65535},
        '{MODE_ALLOC, 17'd1,      16'd0,     1'b0, ST_OK,        16'd0},
        '{MODE_FREE,  17'd0,      16'd1,     1'b0, ST_OK,        16'd0},
        '{MODE_FREE,  17'd0,      16'd1,     1'b0, ST_OK,        16'd0},
        '{MODE_FREE,  17'd0,      16'd0,     1'b0, ST_OK,        16'd0},
        '{MODE_ALLOC, 17'd100,    16'd0,     1'b0, ST_OK,        16'd0},
        '{MODE_FREE,  17'd0,      16'd65535, 1'b0, ST_OK,        16'd0},
        '{MODE_ALLOC, 17'd65536,  16'd0,     1'b0, ST_OK,        16'd0},
        '{MODE_FREE,  17'd0,      16'd0,     1'b0, ST_OK,        16'd0},
        '{MODE_ALLOC, 17'd65536,  16'd0,     1'b0, ST_OK,        16'd0},
        '{MODE_FREE,  17'd0,      16'd0,     1'b0, ST_OK,        16'd0}
    };

    initial begin
        errors = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        tbl_start[0] = 0;
        tbl_size[0] = POOL_BYTES;
        tbl_free[0] = 1'b1;
        tbl_count = 1;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[k])
            send_word(directed[k]);

        send_random(0, 290);
        send_idle_pct = 75;
        send_random(270, 290);
        send_idle_pct = 0;
        recv_stall_pct = 75;
        send_random(0, 290);
        send_idle_pct = 30;
        recv_stall_pct = 30;
        send_random(0, 290);

        req_ch.valid = 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/ffsa_pkg.sv
rtl/ffsa_if.sv
rtl/ffsa_seg_ram.sv
rtl/ffsa_ctrl.sv
rtl/first_fit_segment_allocator.sv
rtl/ffsa_checker.sv
tb/first_fit_segment_allocator_tb.sv
